@@ sv/rmcp_pkg.sv @@
// Shared types, codes and the status-byte classifier for the RTP-MIDI
// command section parser. No dependencies.
`timescale 1ns / 1ps

package rmcp_pkg;

    // Parse phases
    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_HEADER = 3'd1,
        PH_LEN2   = 3'd2,
        PH_DELTA  = 3'd3,
        PH_STATUS = 3'd4,
        PH_DATA1  = 3'd5,
        PH_DATA2  = 3'd6,
        PH_SYSEX  = 3'd7
    } phase_t;

    // Status classes
    typedef enum logic [2:0] {
        CLS_INVALID = 3'd0,
        CLS_ONE     = 3'd1,
        CLS_TWO     = 3'd2,
        CLS_THREE   = 3'd3,
        CLS_SYSEX   = 3'd4
    } status_class_t;

    // Result kinds
    localparam logic [1:0] KIND_MSG   = 2'd0;
    localparam logic [1:0] KIND_SYSEX = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    localparam logic [3:0] HEADER_BYTES  = 4'd12;
    localparam int         SYSEX_MAX_DEF = 128;

    localparam logic [7:0] FLAG_B      = 8'h80;
    localparam logic [7:0] FLAG_Z      = 8'h20;
    localparam logic [7:0] STATUS_SOX  = 8'hF0;
    localparam logic [7:0] STATUS_EOX  = 8'hF7;
    localparam logic [7:0] STATUS_SYS  = 8'hF0;
    localparam logic [7:0] HI_NIBBLE   = 8'hF0;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  msg_type;
        logic [4:0]  channel;
        logic [7:0]  data_first;
        logic [7:0]  data_second;
        logic [7:0]  sysex_byte;
        logic [7:0]  byte_count;
        logic [27:0] delta_time;
        logic        last;
    } result_t;

    // Classify a status byte by message length
    function automatic status_class_t status_class(input logic [7:0] s);
        status_class_t cls;
        cls = CLS_INVALID;
        if (s inside {[8'h80:8'hEF]}) begin
            if (s[7:4] inside {4'hC, 4'hD})
                cls = CLS_TWO;
            else
                cls = CLS_THREE;
        end else begin
            case (s)
                8'hF0:                             cls = CLS_SYSEX;
                8'hF1, 8'hF3:                      cls = CLS_TWO;
                8'hF2:                             cls = CLS_THREE;
                8'hF6, 8'hF8, 8'hFA, 8'hFB,
                8'hFC, 8'hFE, 8'hFF:               cls = CLS_ONE;
                default:                           cls = CLS_INVALID;
            endcase
        end
        return cls;
    endfunction

endpackage

@@ sv/rtp_midi_command_parser.sv @@
// RTP-MIDI command section parser: top level joining the parse core and
// the result skid register. Depends on rmcp_pkg, rmcp_parse_core, rmcp_out_skid.
//
// Usage:
//   Input channel (in_valid/in_ready): one packet byte per transfer, with
//   packet_start high on the first byte of each packet. The 12-byte RTP
//   header is skipped, then the command section is decoded.
//   Output channel (out_valid/out_ready): at most one result per input
//   byte: a complete MIDI message, one SysEx byte, or an invalid-status
//   error after which the rest of the packet is dropped.
//   Throughput: one byte per cycle while in_ready is high; the parse state
//   update from the state registers to the output register is combinational.
//   Result path: a result is registered in the output register, or in the skid
//   register while the output register still holds an earlier result.
//   Stall: the output and skid registers hold up to two results; in_ready
//   drops only while both are full, and no result is lost or repeated.
//   Reset (rst_n low, asynchronous): the parser waits for packet_start and
//   both result registers are emptied.
`timescale 1ns / 1ps

module rtp_midi_command_parser #(
    parameter int SYSEX_MAX = rmcp_pkg::SYSEX_MAX_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        packet_start,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  kind,
    output logic [7:0]  msg_type,
    output logic [4:0]  channel,
    output logic [7:0]  data_first,
    output logic [7:0]  data_second,
    output logic [7:0]  sysex_byte,
    output logic [7:0]  byte_count,
    output logic [27:0] delta_time,
    output logic        last
);
    import rmcp_pkg::*;

    logic    byte_fire;
    logic    res_valid;
    result_t res;
    result_t out_data;

    assign byte_fire = in_valid && in_ready;

    // Decode one byte per transfer
    rmcp_parse_core #(
        .SYSEX_MAX (SYSEX_MAX)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_fire    (byte_fire),
        .data_byte    (data_byte),
        .packet_start (packet_start),
        .res_valid    (res_valid),
        .res          (res)
    );

    // Hold results for the receiver
    rmcp_out_skid u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .can_take  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    assign kind        = out_data.kind;
    assign msg_type    = out_data.msg_type;
    assign channel     = out_data.channel;
    assign data_first  = out_data.data_first;
    assign data_second = out_data.data_second;
    assign sysex_byte  = out_data.sysex_byte;
    assign byte_count  = out_data.byte_count;
    assign delta_time  = out_data.delta_time;
    assign last        = out_data.last;

endmodule

@@ sv/rmcp_parse_core.sv @@
// Per-byte parse state machine: header skip, section length, delta time,
// MIDI message and SysEx decode. Depends on rmcp_pkg.
`timescale 1ns / 1ps

module rmcp_parse_core #(
    parameter int SYSEX_MAX = rmcp_pkg::SYSEX_MAX_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              byte_fire,
    input  logic [7:0]        data_byte,
    input  logic              packet_start,
    output logic              res_valid,
    output rmcp_pkg::result_t res
);
    import rmcp_pkg::*;

    localparam logic [7:0] SysexLimit = 8'(SYSEX_MAX);

    phase_t       phase_reg, phase_next;
    logic [3:0]   hcount_reg, hcount_next;
    logic [11:0]  rem_reg, rem_next;
    logic         fhd_reg, fhd_next;
    logic         seen_reg, seen_next;
    logic [27:0]  dacc_reg, dacc_next;
    logic [1:0]   oct_reg, oct_next;
    logic [7:0]   status_reg, status_next;
    logic [7:0]   dhold_reg, dhold_next;
    logic [7:0]   sxcnt_reg, sxcnt_next;

    logic [11:0]  rem_dec;
    logic         sec_last;
    logic [11:0]  len2_val;
    logic [7:0]   sxcnt_inc;
    logic         sx_end;
    status_class_t cls_in;
    status_class_t cls_held;
    logic [7:0]   msg_status;
    logic [7:0]   msg_type_v;

    // Shared decode terms
    assign rem_dec    = rem_reg - 12'd1;
    assign sec_last   = (rem_dec == 12'd0);
    assign len2_val   = {rem_reg[3:0], data_byte};
    assign sxcnt_inc  = sxcnt_reg + 8'd1;
    assign sx_end     = (data_byte == STATUS_EOX) || sec_last || (sxcnt_inc >= SysexLimit);
    assign cls_in     = status_class(data_byte);
    assign cls_held   = status_class(status_reg);
    assign msg_status = (phase_reg == PH_STATUS) ? data_byte : status_reg;
    assign msg_type_v = (msg_status < STATUS_SYS) ? (msg_status & HI_NIBBLE) : msg_status;

    // Next state
    always_comb
    begin
        phase_next  = phase_reg;
        hcount_next = hcount_reg;
        rem_next    = rem_reg;
        fhd_next    = fhd_reg;
        seen_next   = seen_reg;
        dacc_next   = dacc_reg;
        oct_next    = oct_reg;
        status_next = status_reg;
        dhold_next  = dhold_reg;
        sxcnt_next  = sxcnt_reg;
        if (byte_fire) begin
            if (packet_start) begin
                phase_next  = PH_HEADER;
                hcount_next = 4'd1;
            end else begin
                case (phase_reg)
                    PH_IDLE:
                    begin
                    end
                    PH_HEADER:
                    begin
                        if (hcount_reg < HEADER_BYTES) begin
                            hcount_next = hcount_reg + 4'd1;
                        end else begin
                            rem_next  = {8'd0, data_byte[3:0]};
                            fhd_next  = (data_byte & FLAG_Z) != 8'd0;
                            seen_next = 1'b0;
                            if ((data_byte & FLAG_B) != 8'd0) begin
                                phase_next = PH_LEN2;
                            end else begin
                                dacc_next = '0;
                                oct_next  = '0;
                                if (data_byte[3:0] == 4'd0)
                                    phase_next = PH_IDLE;
                                else if ((data_byte & FLAG_Z) != 8'd0)
                                    phase_next = PH_DELTA;
                                else
                                    phase_next = PH_STATUS;
                            end
                        end
                    end
                    PH_LEN2:
                    begin
                        rem_next  = len2_val;
                        dacc_next = '0;
                        oct_next  = '0;
                        if (len2_val == 12'd0)
                            phase_next = PH_IDLE;
                        else if (seen_reg || fhd_reg)
                            phase_next = PH_DELTA;
                        else
                            phase_next = PH_STATUS;
                    end
                    default:
                    begin
                        if (rem_reg == 12'd0) begin
                            phase_next = PH_IDLE;
                        end else begin
                            rem_next = rem_dec;
                            case (phase_reg)
                                PH_DELTA:
                                begin
                                    dacc_next = {dacc_reg[20:0], data_byte[6:0]};
                                    if (!data_byte[7] || oct_reg == 2'd3) begin
                                        oct_next   = '0;
                                        phase_next = sec_last ? PH_IDLE : PH_STATUS;
                                    end else begin
                                        oct_next = oct_reg + 2'd1;
                                        if (sec_last)
                                            phase_next = PH_IDLE;
                                    end
                                end
                                PH_STATUS:
                                begin
                                    status_next = data_byte;
                                    seen_next   = 1'b1;
                                    case (cls_in)
                                        CLS_INVALID:
                                            phase_next = PH_IDLE;
                                        CLS_ONE:
                                        begin
                                            dacc_next  = '0;
                                            oct_next   = '0;
                                            phase_next = sec_last ? PH_IDLE : PH_DELTA;
                                        end
                                        CLS_SYSEX:
                                        begin
                                            sxcnt_next = 8'd1;
                                            if (sec_last || (8'd1 >= SysexLimit)) begin
                                                dacc_next  = '0;
                                                oct_next   = '0;
                                                phase_next = sec_last ? PH_IDLE : PH_DELTA;
                                            end else begin
                                                phase_next = PH_SYSEX;
                                            end
                                        end
                                        default:
                                            phase_next = sec_last ? PH_IDLE : PH_DATA1;
                                    endcase
                                end
                                PH_DATA1:
                                begin
                                    if (cls_held == CLS_TWO) begin
                                        dacc_next  = '0;
                                        oct_next   = '0;
                                        phase_next = sec_last ? PH_IDLE : PH_DELTA;
                                    end else begin
                                        dhold_next = data_byte;
                                        phase_next = sec_last ? PH_IDLE : PH_DATA2;
                                    end
                                end
                                PH_DATA2:
                                begin
                                    dacc_next  = '0;
                                    oct_next   = '0;
                                    phase_next = sec_last ? PH_IDLE : PH_DELTA;
                                end
                                PH_SYSEX:
                                begin
                                    sxcnt_next = sxcnt_inc;
                                    if (sx_end) begin
                                        dacc_next  = '0;
                                        oct_next   = '0;
                                        phase_next = sec_last ? PH_IDLE : PH_DELTA;
                                    end
                                end
                                default:
                                    phase_next = PH_IDLE;
                            endcase
                        end
                    end
                endcase
            end
        end
    end

    // Result for the byte being taken
    always_comb
    begin
        res_valid       = 1'b0;
        res             = '0;
        res.delta_time  = dacc_reg;
        res.msg_type    = msg_type_v;
        res.channel     = 5'({1'b0, msg_status[3:0]} + 5'd1);
        if (byte_fire && !packet_start && rem_reg != 12'd0) begin
            case (phase_reg)
                PH_STATUS:
                begin
                    case (cls_in)
                        CLS_INVALID:
                        begin
                            res_valid    = 1'b1;
                            res.kind     = KIND_ERROR;
                            res.msg_type = '0;
                            res.channel  = '0;
                        end
                        CLS_ONE:
                        begin
                            res_valid      = 1'b1;
                            res.kind       = KIND_MSG;
                            res.channel    = '0;
                            res.byte_count = 8'd1;
                        end
                        CLS_SYSEX:
                        begin
                            res_valid      = 1'b1;
                            res.kind       = KIND_SYSEX;
                            res.msg_type   = STATUS_SOX;
                            res.channel    = '0;
                            res.sysex_byte = data_byte;
                            if (sec_last || (8'd1 >= SysexLimit)) begin
                                res.last       = 1'b1;
                                res.byte_count = 8'd1;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
                PH_DATA1:
                begin
                    if (cls_held == CLS_TWO) begin
                        res_valid      = 1'b1;
                        res.kind       = KIND_MSG;
                        res.data_first = data_byte;
                        res.byte_count = 8'd2;
                    end
                end
                PH_DATA2:
                begin
                    res_valid       = 1'b1;
                    res.kind        = KIND_MSG;
                    res.data_first  = dhold_reg;
                    res.data_second = data_byte;
                    res.byte_count  = 8'd3;
                end
                PH_SYSEX:
                begin
                    res_valid      = 1'b1;
                    res.kind       = KIND_SYSEX;
                    res.msg_type   = STATUS_SOX;
                    res.channel    = '0;
                    res.sysex_byte = data_byte;
                    if (sx_end) begin
                        res.last       = 1'b1;
                        res.byte_count = sxcnt_inc;
                    end
                end
                default:
                begin
                end
            endcase
        end
        if (!res_valid)
            res = '0;
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg  <= PH_IDLE;
            hcount_reg <= '0;
            rem_reg    <= '0;
            fhd_reg    <= 1'b0;
            seen_reg   <= 1'b0;
            dacc_reg   <= '0;
            oct_reg    <= '0;
            status_reg <= '0;
            dhold_reg  <= '0;
            sxcnt_reg  <= '0;
        end else begin
            phase_reg  <= phase_next;
            hcount_reg <= hcount_next;
            rem_reg    <= rem_next;
            fhd_reg    <= fhd_next;
            seen_reg   <= seen_next;
            dacc_reg   <= dacc_next;
            oct_reg    <= oct_next;
            status_reg <= status_next;
            dhold_reg  <= dhold_next;
            sxcnt_reg  <= sxcnt_next;
        end
    end

endmodule

@@ sv/rmcp_out_skid.sv @@
// Two-entry result register (output stage plus skid stage) that lets the
// parser keep taking bytes while a result waits. Depends on rmcp_pkg.
`timescale 1ns / 1ps

module rmcp_out_skid (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  rmcp_pkg::result_t push_data,
    output logic              can_take,
    output logic              out_valid,
    input  logic              out_ready,
    output rmcp_pkg::result_t out_data
);
    import rmcp_pkg::*;

    logic    ovalid_reg, ovalid_next;
    logic    svalid_reg, svalid_next;
    result_t odata_reg, odata_next;
    result_t sdata_reg, sdata_next;
    logic    pop;

    assign pop       = ovalid_reg && out_ready;
    assign can_take  = !svalid_reg;
    assign out_valid = ovalid_reg;
    assign out_data  = odata_reg;

    // Load new results and move them between the skid and output stages
    always_comb
    begin
        ovalid_next = ovalid_reg;
        svalid_next = svalid_reg;
        odata_next  = odata_reg;
        sdata_next  = sdata_reg;
        if (svalid_reg) begin
            if (pop) begin
                odata_next  = sdata_reg;
                svalid_next = 1'b0;
            end
        end else if (!ovalid_reg || pop) begin
            ovalid_next = push;
            if (push)
                odata_next = push_data;
        end else if (push) begin
            sdata_next  = push_data;
            svalid_next = 1'b1;
        end
    end

    // Control flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            ovalid_reg <= 1'b0;
            svalid_reg <= 1'b0;
        end else begin
            ovalid_reg <= ovalid_next;
            svalid_reg <= svalid_next;
        end
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        odata_reg <= odata_next;
        sdata_reg <= sdata_next;
    end

endmodule
